// File: hw/rtl/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rau check failed");

// implication whose consequent is checked in the following cycle
`define RAU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rau check failed");

`endif

// File: hw/rtl/rau_pkg.sv
package rau_pkg;
   localparam int unsigned OperandWidthDefault = 32;
   localparam int unsigned ResWidth = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_LT  = 2'd3
   } opcode_type;

   // one shared unit: 64x64 multiply (low half) or divide, bit-serial
   typedef enum logic [1:0] {
      UNIT_MUL  = 2'd0,
      UNIT_DIV  = 2'd1
   } unit_op_type;
endpackage

// File: hw/rtl/rau_seq_unit.sv
// shared shift-add multiplier / shift-subtract divider, one bit per cycle
module rau_seq_unit
   import rau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  unit_op_type           op,
   input  logic [ResWidth-1:0]   opa,
   input  logic [ResWidth-1:0]   opb,
   output logic                  done,
   output logic [ResWidth-1:0]   quo,
   output logic [ResWidth-1:0]   rem
);
   localparam int unsigned CntWidth = $clog2(ResWidth + 1);

   logic                  busy_ff, busy_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   unit_op_type           op_ff, op_in;
   logic [ResWidth-1:0]   acc_ff, acc_in;   // product or remainder
   logic [ResWidth-1:0]   sh_ff, sh_in;     // shifting multiplier or dividend/quotient
   logic [ResWidth-1:0]   b_ff, b_in;       // multiplicand or |divisor|
   logic                  qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic                  done_ff, done_in;
   logic [ResWidth:0]     trial;
   logic [ResWidth-1:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      done_in = 1'b0;
      rem_sh  = '0;
      trial   = '0;
      if (go && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         op_in   = op;
         acc_in  = '0;
         if (op == UNIT_MUL) begin
            sh_in = opb;
            b_in  = opa;
         end else begin
            sh_in   = opa[ResWidth-1] ? (~opa + 1'b1) : opa;
            b_in    = opb[ResWidth-1] ? (~opb + 1'b1) : opb;
            qneg_in = opa[ResWidth-1] ^ opb[ResWidth-1];
            rneg_in = opa[ResWidth-1];
         end
      end else if (busy_ff) begin
         if (op_ff == UNIT_MUL) begin
            if (sh_ff[0]) acc_in = acc_ff + b_ff;
            sh_in  = sh_ff >> 1;
            b_in   = b_ff << 1;
         end else begin
            rem_sh = {acc_ff[ResWidth-2:0], sh_ff[ResWidth-1]};
            trial  = {1'b0, rem_sh} - {1'b0, b_ff};
            if (!trial[ResWidth] || acc_ff[ResWidth-1]) begin
               acc_in = trial[ResWidth-1:0];
               sh_in  = {sh_ff[ResWidth-2:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               sh_in  = {sh_ff[ResWidth-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(ResWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      b_ff    <= b_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done = done_ff;
   always_comb begin
      if (op_ff == UNIT_MUL) begin
         quo = acc_ff;
         rem = '0;
      end else begin
         quo = qneg_ff ? (~sh_ff + 1'b1) : sh_ff;
         rem = rneg_ff ? (~acc_ff + 1'b1) : acc_ff;
      end
   end
endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: add, multiply, divide, less-than of two fractions
// each product or remainder step holds the sequencer in ST_WAIT on the one shared
//   bit-serial multiply/divide unit; the gcd remainder loop sets the total length
// throughput: one item at a time, busy high from accept until the result strobe
// reset: synchronous active-high, sequencer idle, no results pending; receiver cannot stall
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                       rsp_valid,
   output logic signed [ResWidth-1:0] rsp_res_num,
   output logic signed [ResWidth-1:0] rsp_res_den,
   output logic                       rsp_less_than,
   output logic                       rsp_zero_den_fixed
);
   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_P0    = 10'b0000000010,  // first product
      ST_P1    = 10'b0000000100,  // second product
      ST_P2    = 10'b0000001000,  // third product (add denominator)
      ST_FORM  = 10'b0000010000,  // form result or compare, fix zero denominator
      ST_GCD   = 10'b0000100000,  // one euclid remainder step
      ST_DN    = 10'b0001000000,  // numerator / gcd
      ST_DD    = 10'b0010000000,  // denominator / gcd
      ST_OUT   = 10'b0100000000,
      ST_WAIT  = 10'b1000000000   // wait for shared unit
   } state_type;

   state_type             state_ff, state_in, ret_ff, ret_in;
   opcode_type            op_ff, op_in;
   logic [ResWidth-1:0]   an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [ResWidth-1:0]   p0_ff, p0_in, p1_ff, p1_in;
   logic [ResWidth-1:0]   rn_ff, rn_in, rd_ff, rd_in;
   logic [ResWidth-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic                  fix_ff, fix_in, lt_ff, lt_in, valid_ff, valid_in;

   logic                  u_go, u_done;
   unit_op_type           u_op;
   logic [ResWidth-1:0]   u_a, u_b, u_quo, u_rem;
   logic [ResWidth-1:0]   sa_num, sa_den, sb_num, sb_den;

   assign sa_num = ResWidth'(req_a_num);
   assign sa_den = ResWidth'(req_a_den);
   assign sb_num = ResWidth'(req_b_num);
   assign sb_den = ResWidth'(req_b_den);

   rau_seq_unit u_unit (
      .clock (clock), .reset (reset), .go (u_go), .op (u_op),
      .opa (u_a), .opb (u_b), .done (u_done), .quo (u_quo), .rem (u_rem)
   );

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      op_in    = op_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p0_in = p0_ff; p1_in = p1_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      fix_in = fix_ff; lt_in = lt_ff;
      valid_in = 1'b0;
      u_go = 1'b0; u_op = UNIT_MUL; u_a = '0; u_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = opcode_type'(req_opcode);
               fix_in = 1'b0;
               lt_in  = 1'b0;
               an_in = sa_num; ad_in = sa_den; bn_in = sb_num; bd_in = sb_den;
               if (sa_den == '0) begin
                  an_in = '0; ad_in = ResWidth'(1); fix_in = 1'b1;
               end
               if (sb_den == '0) begin
                  bn_in = '0; bd_in = ResWidth'(1); fix_in = 1'b1;
               end
               state_in = ST_P0;
            end
         end
         ST_P0: begin
            // add with equal denominators skips the products
            if (op_ff == OP_ADD && ad_ff == bd_ff) begin
               rn_in = an_ff + bn_ff;
               rd_in = ad_ff;
               state_in = ST_FORM;
            end else begin
               u_go = 1'b1;
               u_a = an_ff;
               u_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
               ret_in = ST_P1;
               state_in = ST_WAIT;
            end
         end
         ST_P1: begin
            p0_in = u_quo;
            u_go = 1'b1;
            u_a = (op_ff == OP_DIV) ? ad_ff : ((op_ff == OP_MUL) ? ad_ff : bn_ff);
            u_b = (op_ff == OP_DIV) ? bn_ff : ad_ff;
            if (op_ff == OP_MUL) u_b = bd_ff;
            ret_in = (op_ff == OP_ADD) ? ST_P2 : ST_FORM;
            state_in = ST_WAIT;
         end
         ST_P2: begin
            p1_in = u_quo;
            u_go = 1'b1;
            u_a = ad_ff;
            u_b = bd_ff;
            ret_in = ST_FORM;
            state_in = ST_WAIT;
         end
         ST_FORM: begin
            state_in = ST_GCD;
            if (op_ff == OP_LT) begin
               lt_in = $signed(p0_ff) < $signed(u_quo);
               rn_in = '0; rd_in = ResWidth'(1);
               state_in = ST_OUT;
            end else begin
               if (op_ff == OP_ADD && ad_ff != bd_ff) begin
                  rn_in = p0_ff + p1_ff;
                  rd_in = u_quo;
               end else if (op_ff != OP_ADD) begin
                  rn_in = p0_ff;
                  rd_in = u_quo;
               end
               if (rd_in == '0) begin
                  rn_in = '0; rd_in = ResWidth'(1); fix_in = 1'b1;
               end
               gx_in = rn_in;
               gy_in = rd_in;
            end
         end
         ST_GCD: begin
            if (gy_ff == '0) begin
               if (!gx_ff[ResWidth-1] && gx_ff > ResWidth'(1)) begin
                  u_go = 1'b1; u_op = UNIT_DIV; u_a = rn_ff; u_b = gx_ff;
                  ret_in = ST_DN;
                  state_in = ST_WAIT;
               end else begin
                  state_in = ST_OUT;
               end
            end else if (gy_ff == '1) begin
               // remainder by minus one is zero
               gx_in = gy_ff;
               gy_in = '0;
            end else begin
               u_go = 1'b1; u_op = UNIT_DIV; u_a = gx_ff; u_b = gy_ff;
               ret_in = ST_GCD;
               state_in = ST_WAIT;
            end
         end
         ST_DN: begin
            rn_in = u_quo;
            u_go = 1'b1; u_op = UNIT_DIV; u_a = rd_ff; u_b = gx_ff;
            ret_in = ST_DD;
            state_in = ST_WAIT;
         end
         ST_DD: begin
            rd_in = u_quo;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WAIT: begin
            if (u_done) begin
               if (ret_ff == ST_GCD) begin
                  gx_in = gy_ff;
                  gy_in = u_rem;
               end else begin
                  state_in = ret_ff;
               end
               if (ret_ff == ST_GCD) state_in = ST_GCD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // compare op: after second product go straight to form
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      ret_ff <= ret_in;
      op_ff  <= op_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p0_ff <= p0_in; p1_ff <= p1_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      fix_ff <= fix_in; lt_ff <= lt_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_res_num        = rn_ff;
   assign rsp_res_den        = rd_ff;
   assign rsp_less_than      = lt_ff;
   assign rsp_zero_den_fixed = fix_ff;

`include "rational_arithmetic_unit_assert.svh"

   // a result strobe always follows the output state
   `RAU_ASSERT_NEXT(a_out_strobe, state_ff == ST_OUT, rsp_valid && state_ff == ST_IDLE)
   // results appear only while the sequencer is idle, never while busy
   `RAU_ASSERT_IMP(a_valid_idle, rsp_valid, !busy)
   // a compare always returns 0/1
   `RAU_ASSERT_IMP(a_cmp_unit, rsp_valid && op_ff == OP_LT,
      rsp_res_num == '0 && rsp_res_den == ResWidth'(1))
endmodule
